### sv/tlbf_pkg.sv
// shared constants, state type and field positions of the tlb page translation unit
package tlbf_pkg;

	// default sizes
	localparam int TLBF_TLB_ENTRIES = 16;
	localparam int TLBF_NUM_PAGES   = 256;
	localparam int TLBF_NUM_FRAMES  = 128;

	// field widths of the stream items
	localparam int VA_W       = 16;
	localparam int PAGE_FLD_W = 8;
	localparam int OFFSET_W   = 8;
	localparam int FRAME_O_W  = 7;
	localparam int PHYS_W     = 15;
	localparam int S_TDATA_W  = 16;
	localparam int M_TDATA_W  = 24;
	localparam int M_TUSER_W  = 3;

	// result flag positions in m_tuser
	localparam int USER_HIT    = 0;
	localparam int USER_FAULT  = 1;
	localparam int USER_NOFREE = 2;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_SCAN,
		ST_UPDATE,
		ST_RESP
	} tlbf_state_t;

endpackage

### sv/tlbf_tlb.sv
// tlb entry store with fifo write port and the shared page compare unit
module tlbf_tlb import tlbf_pkg::*; #(
	parameter int TLB_ENTRIES = TLBF_TLB_ENTRIES,
	parameter int IDX_W       = 4,
	parameter int PAGE_W      = 8,
	parameter int FRAME_W     = 7
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rd_en,
	input  logic [IDX_W-1:0]   rd_idx,
	input  logic [PAGE_W-1:0]  cmp_page,
	output logic               match,
	output logic [FRAME_W-1:0] rd_frame,
	input  logic               wr_en,
	input  logic [IDX_W-1:0]   wr_idx,
	input  logic [PAGE_W-1:0]  wr_page,
	input  logic [FRAME_W-1:0] wr_frame
);

	logic [TLB_ENTRIES-1:0] valid_q;
	logic [PAGE_W-1:0]      page_mem [TLB_ENTRIES];
	logic [FRAME_W-1:0]     frame_mem [TLB_ENTRIES];
	logic                   rd_valid_q;
	logic [PAGE_W-1:0]      rd_page_q;
	logic [FRAME_W-1:0]     rd_frame_q;

	// valid bits, cleared at once by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_idx] <= 1'b1;
		end
	end

	// entry memory, one write and one registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			page_mem[wr_idx]  <= wr_page;
			frame_mem[wr_idx] <= wr_frame;
		end
		if (rd_en) begin
			rd_valid_q <= valid_q[rd_idx];
			rd_page_q  <= page_mem[rd_idx];
			rd_frame_q <= frame_mem[rd_idx];
		end
	end

	// shared compare of the entry just read
	assign match    = rd_valid_q && (rd_page_q == cmp_page);
	assign rd_frame = rd_frame_q;

endmodule

### sv/tlbf_pt.sv
// page table: frame memory with a valid bit per page
module tlbf_pt import tlbf_pkg::*; #(
	parameter int NUM_PAGES = TLBF_NUM_PAGES,
	parameter int PAGE_W    = 8,
	parameter int FRAME_W   = 7
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [PAGE_W-1:0]  rd_idx,
	output logic               rd_valid,
	output logic [FRAME_W-1:0] rd_frame,
	input  logic               wr_en,
	input  logic [PAGE_W-1:0]  wr_idx,
	input  logic [FRAME_W-1:0] wr_frame
);

	logic [NUM_PAGES-1:0] valid_q;
	logic [FRAME_W-1:0]   frame_mem [NUM_PAGES];
	logic                 rd_valid_q;
	logic [FRAME_W-1:0]   rd_frame_q;

	// mapped flags, cleared at once by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_idx] <= 1'b1;
		end
	end

	// frame memory, registered read every cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			frame_mem[wr_idx] <= wr_frame;
		end
		rd_valid_q <= valid_q[rd_idx];
		rd_frame_q <= frame_mem[rd_idx];
	end

	assign rd_valid = rd_valid_q;
	assign rd_frame = rd_frame_q;

endmodule

### sv/tlb_fifo_page_translate_unit.sv
// Sequence: accept, page-modulo reduction by repeated subtraction, a TLB scan of one entry
// per cycle through the single page comparator, an update on a miss, then the output load.
// The block takes no new item until the result is loaded into the output register.
// Reset: arst_n clears all TLB and page table valid bits, the fifo pointer and the frame
// counter at once; no clearing pass, the block is ready in the first cycle after reset.
module tlb_fifo_page_translate_unit import tlbf_pkg::*; #(
	parameter int TLB_ENTRIES = TLBF_TLB_ENTRIES,
	parameter int NUM_PAGES   = TLBF_NUM_PAGES,
	parameter int NUM_FRAMES  = TLBF_NUM_FRAMES
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // [15:0] virt_addr
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,  // [6:0] frame_num, [21:7] phys_addr, [23:22] zero
	output logic [M_TUSER_W-1:0] m_tuser   // [0] tlb_hit, [1] page_fault, [2] no_free_frame
);

	localparam int IDX_W   = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
	localparam int SCNT_W  = $clog2(TLB_ENTRIES + 1);
	localparam int PAGE_W  = $clog2(NUM_PAGES);
	localparam int FRAME_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
	localparam int FCNT_W  = $clog2(NUM_FRAMES + 1);

	tlbf_state_t state_q, state_d;

	logic [PAGE_FLD_W-1:0] page_q;
	logic [OFFSET_W-1:0]   offset_q;
	logic [SCNT_W-1:0]     scan_idx_q;
	logic                  rd_pending_q;
	logic [IDX_W-1:0]      fill_ptr_q;
	logic [FCNT_W-1:0]     free_cnt_q;
	logic [FRAME_W-1:0]    res_frame_q;
	logic                  res_hit_q;
	logic                  res_fault_q;
	logic                  res_nofree_q;
	logic                  m_tvalid_q;
	logic [M_TDATA_W-1:0]  m_tdata_q;
	logic [M_TUSER_W-1:0]  m_tuser_q;

	logic               page_big;
	logic               scan_end;
	logic               issue;
	logic               scan_hit;
	logic               scan_miss;
	logic               frames_full;
	logic               alloc;
	logic               nofree_now;
	logic               tlb_wr_en;
	logic               pt_wr_en;
	logic               out_load;
	logic [FRAME_W-1:0] upd_frame;
	logic               tlb_match;
	logic [FRAME_W-1:0] tlb_rd_frame;
	logic               pt_rd_valid;
	logic [FRAME_W-1:0] pt_rd_frame;
	logic [7:0]         frame8;
	logic [PHYS_W-1:0]  phys;

	// datapath conditions
	assign page_big    = {1'b0, page_q} >= 9'(NUM_PAGES);
	assign scan_end    = scan_idx_q == SCNT_W'(TLB_ENTRIES);
	assign frames_full = free_cnt_q == FCNT_W'(NUM_FRAMES);
	assign upd_frame   = pt_rd_valid ? pt_rd_frame : free_cnt_q[FRAME_W-1:0];

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_REDUCE;
			end
			ST_REDUCE: begin
				if (!page_big) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (scan_hit) state_d = ST_RESP;
				else if (scan_miss) state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				state_d = ST_RESP;
			end
			ST_RESP: begin
				if (out_load) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready   = 1'b0;
		issue      = 1'b0;
		scan_hit   = 1'b0;
		scan_miss  = 1'b0;
		alloc      = 1'b0;
		nofree_now = 1'b0;
		tlb_wr_en  = 1'b0;
		pt_wr_en   = 1'b0;
		out_load   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
			end
			ST_SCAN: begin
				scan_hit  = rd_pending_q && tlb_match;
				scan_miss = scan_end && !scan_hit;
				issue     = !scan_hit && !scan_end;
			end
			ST_UPDATE: begin
				nofree_now = !pt_rd_valid && frames_full;
				alloc      = !pt_rd_valid && !frames_full;
				tlb_wr_en  = !nofree_now;
				pt_wr_en   = alloc;
			end
			ST_RESP: begin
				out_load = !m_tvalid_q || m_tready;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// item registers: page reduction by repeated subtraction, scan counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q   <= '0;
			rd_pending_q <= 1'b0;
		end else begin
			rd_pending_q <= issue;
			if (state_q == ST_REDUCE) begin
				scan_idx_q <= '0;
			end else if (issue) begin
				scan_idx_q <= scan_idx_q + SCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			page_q   <= s_tdata[VA_W-1:OFFSET_W];
			offset_q <= s_tdata[OFFSET_W-1:0];
		end else if (state_q == ST_REDUCE && page_big) begin
			page_q <= page_q - PAGE_FLD_W'(NUM_PAGES);
		end
	end

	// fifo pointer and frame allocator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_ptr_q <= '0;
			free_cnt_q <= '0;
		end else begin
			if (tlb_wr_en) begin
				if (fill_ptr_q == IDX_W'(TLB_ENTRIES - 1)) fill_ptr_q <= '0;
				else fill_ptr_q <= fill_ptr_q + IDX_W'(1);
			end
			if (alloc) begin
				free_cnt_q <= free_cnt_q + FCNT_W'(1);
			end
		end
	end

	// result of the current item
	always_ff @(posedge clk) begin
		if (scan_hit) begin
			res_frame_q  <= tlb_rd_frame;
			res_hit_q    <= 1'b1;
			res_fault_q  <= 1'b0;
			res_nofree_q <= 1'b0;
		end else if (state_q == ST_UPDATE) begin
			res_frame_q  <= nofree_now ? '0 : upd_frame;
			res_hit_q    <= 1'b0;
			res_fault_q  <= alloc;
			res_nofree_q <= nofree_now;
		end
	end

	// output register
	assign frame8 = 8'(res_frame_q);
	assign phys   = res_nofree_q ? '0 : {frame8[FRAME_O_W-1:0], offset_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q                 <= {2'b00, phys, frame8[FRAME_O_W-1:0]};
			m_tuser_q[USER_HIT]    <= res_hit_q;
			m_tuser_q[USER_FAULT]  <= res_fault_q;
			m_tuser_q[USER_NOFREE] <= res_nofree_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// tlb store and compare unit
	tlbf_tlb #(
		.TLB_ENTRIES(TLB_ENTRIES),
		.IDX_W      (IDX_W),
		.PAGE_W     (PAGE_W),
		.FRAME_W    (FRAME_W)
	) u_tlb (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (issue),
		.rd_idx  (scan_idx_q[IDX_W-1:0]),
		.cmp_page(page_q[PAGE_W-1:0]),
		.match   (tlb_match),
		.rd_frame(tlb_rd_frame),
		.wr_en   (tlb_wr_en),
		.wr_idx  (fill_ptr_q),
		.wr_page (page_q[PAGE_W-1:0]),
		.wr_frame(upd_frame)
	);

	// page table
	tlbf_pt #(
		.NUM_PAGES(NUM_PAGES),
		.PAGE_W   (PAGE_W),
		.FRAME_W  (FRAME_W)
	) u_pt (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_idx  (page_q[PAGE_W-1:0]),
		.rd_valid(pt_rd_valid),
		.rd_frame(pt_rd_frame),
		.wr_en   (pt_wr_en),
		.wr_idx  (page_q[PAGE_W-1:0]),
		.wr_frame(free_cnt_q[FRAME_W-1:0])
	);

	// checks
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q |-> $onehot0(m_tuser_q))
		else $error("more than one result flag set");

	a_free_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		free_cnt_q <= FCNT_W'(NUM_FRAMES))
		else $error("frame counter past frame count");

	a_free_cnt_only_update: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_UPDATE |=> free_cnt_q == $past(free_cnt_q))
		else $error("frame counter moved outside update");

	a_nofree_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && m_tuser_q[USER_NOFREE]) |-> frames_full)
		else $error("no free frame reported with frames left");

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// testbench for the tlb page translation unit: directed, random and frame exhaustion traffic
module testbench;
	import tlbf_pkg::*;

	// one translation result, tagged with the address that caused it
	typedef struct packed {
		logic [VA_W-1:0]      va;
		logic [FRAME_O_W-1:0] frame;
		logic [PHYS_W-1:0]    phys;
		logic                 hit;
		logic                 fault;
		logic                 nofree;
	} xlate_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [M_TUSER_W-1:0] m_tuser;

	// translation state mirrored by the testbench
	bit                    tlb_v  [TLBF_TLB_ENTRIES];
	logic [PAGE_FLD_W-1:0] tlb_pg [TLBF_TLB_ENTRIES];
	logic [FRAME_O_W-1:0]  tlb_fr [TLBF_TLB_ENTRIES];
	int                    tlb_next;
	bit                    pt_v   [TLBF_NUM_PAGES];
	logic [FRAME_O_W-1:0]  pt_fr  [TLBF_NUM_PAGES];
	int                    frames_used;
	logic [PAGE_FLD_W-1:0] mapped_pages [$];

	xlate_t expected_xlates [$];
	int     mismatches;
	int     results_seen;
	int     n_hit, n_walk, n_fault, n_nofree;
	bit     steady;
	int     stall_left;

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	tlb_fifo_page_translate_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// translate one address and update the mirrored tlb and page table
	function automatic xlate_t translate_va(input logic [VA_W-1:0] va);
		xlate_t r;
		int     pg;
		int     off;
		int     fr;
		int     i;
		bit     found;
		r = '0;
		r.va = va;
		pg = va[VA_W-1 -: PAGE_FLD_W] % TLBF_NUM_PAGES;
		off = va[OFFSET_W-1:0];
		found = 1'b0;
		fr = 0;
		for (i = 0; i < TLBF_TLB_ENTRIES && !found; i++) begin
			if (tlb_v[i] && tlb_pg[i] == pg) begin
				found = 1'b1;
				fr = tlb_fr[i];
			end
		end
		if (found) begin
			r.hit = 1'b1;
			n_hit++;
		end else if (!pt_v[pg] && frames_used >= TLBF_NUM_FRAMES) begin
			// out of frames: zero frame and address, nothing changes
			r.nofree = 1'b1;
			n_nofree++;
		end else begin
			if (pt_v[pg]) begin
				fr = pt_fr[pg];
				n_walk++;
			end else begin
				fr = frames_used & 'hFF;
				frames_used++;
				pt_v[pg] = 1'b1;
				pt_fr[pg] = FRAME_O_W'(fr);
				mapped_pages.push_back(PAGE_FLD_W'(pg));
				r.fault = 1'b1;
				n_fault++;
			end
			// fifo refill of the tlb
			if (tlb_next >= TLBF_TLB_ENTRIES)
				tlb_next = 0;
			tlb_v[tlb_next] = 1'b1;
			tlb_pg[tlb_next] = PAGE_FLD_W'(pg);
			tlb_fr[tlb_next] = FRAME_O_W'(fr);
			tlb_next = (tlb_next + 1) % TLBF_TLB_ENTRIES;
		end
		if (!r.nofree) begin
			r.frame = FRAME_O_W'(fr);
			r.phys = PHYS_W'((fr << PAGE_FLD_W) + off);
		end
		return r;
	endfunction

	// idle length: mostly short, now and then long
	function automatic int gap_len();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(8, 30);
		return $urandom_range(0, 2);
	endfunction

	// send one address and record its expected translation
	task automatic send_va(input logic [VA_W-1:0] va);
		int gap;
		gap = 0;
		if (!steady && $urandom_range(0, 2) == 0)
			gap = gap_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= va;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		expected_xlates.push_back(translate_va(va));
	endtask

	// hold off the sender until every translation has come back
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (expected_xlates.size() != 0);
	endtask

	// address extremes, hits right after faults, and fifo eviction of the tlb
	task automatic test_directed();
		logic [VA_W-1:0] firsts [$];
		int              p;
		firsts = '{16'h0000, 16'h00FF, 16'hFFFF, 16'hFF00, 16'hAA55, 16'h55AA};
		foreach (firsts[k])
			send_va(firsts[k]);
		// sixteen fresh pages push pages 00 and ff out of the tlb
		for (p = 16'h10; p < 16'h20; p++)
			send_va({PAGE_FLD_W'(p), OFFSET_W'($urandom_range(0, 255))});
		// evicted pages come back through the page table
		send_va(16'h0080);
		send_va(16'hFF7F);
		drain();
	endtask

	// random traffic around a working set, with some fresh pages
	task automatic test_random_traffic(input int n, input int pct_new);
		int                    k;
		int                    r;
		int                    sz;
		logic [PAGE_FLD_W-1:0] pg;
		for (k = 0; k < n; k++) begin
			if (k % 100 == 0)
				steady = ($urandom_range(0, 3) == 0);
			if (k % 150 == 149)
				drain();
			r = $urandom_range(0, 99);
			sz = mapped_pages.size();
			if (sz == 0 || r < pct_new)
				pg = PAGE_FLD_W'($urandom_range(0, 255));
			else if (r < pct_new + 40)
				pg = mapped_pages[sz - 1 - $urandom_range(0, (sz > 12) ? 11 : sz - 1)];
			else
				pg = mapped_pages[$urandom_range(0, sz - 1)];
			send_va({pg, OFFSET_W'($urandom_range(0, 255))});
		end
		steady = 1'b0;
		drain();
	endtask

	// sweep unmapped pages until the frames run out, then a few more
	task automatic test_exhaustion();
		int p;
		int start_nofree;
		start_nofree = n_nofree;
		for (p = 0; p < TLBF_NUM_PAGES && n_nofree - start_nofree < 6; p++) begin
			if (!pt_v[p])
				send_va({PAGE_FLD_W'(p), OFFSET_W'($urandom_range(0, 255))});
		end
		drain();
	endtask

	// receiver stalls
	always @(posedge clk) begin
		if (steady) begin
			m_tready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if ($urandom_range(0, 3) == 0) begin
			stall_left = gap_len();
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// compare each result item with the oldest expected translation
	always @(posedge clk) begin : check_result
		xlate_t want;
		xlate_t got;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			got = '0;
			got.frame = m_tdata[FRAME_O_W-1:0];
			got.phys = m_tdata[FRAME_O_W +: PHYS_W];
			got.hit = m_tuser[USER_HIT];
			got.fault = m_tuser[USER_FAULT];
			got.nofree = m_tuser[USER_NOFREE];
			if (expected_xlates.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: frame %0d phys %h hit %b fault %b nofree %b",
						got.frame, got.phys, got.hit, got.fault, got.nofree);
			end else begin
				want = expected_xlates.pop_front();
				got.va = want.va;
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("va %h: expected frame %0d phys %h hit %b fault %b nofree %b",
							want.va, want.frame, want.phys, want.hit, want.fault, want.nofree);
						$display("  got frame %0d phys %h hit %b fault %b nofree %b",
							got.frame, got.phys, got.hit, got.fault, got.nofree);
					end
				end
			end
		end
	end

	// test sequence
	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_traffic(800, 25);
		test_exhaustion();
		test_random_traffic(550, 50);
		drain();
		repeat (40) @(posedge clk);
		$display("%0d translations checked: %0d tlb hits, %0d table walks, %0d page faults",
			results_seen, n_hit, n_walk, n_fault);
		$display("%0d faults with no frame left, %0d of %0d frames handed out, %0d mismatches",
			n_nofree, frames_used, TLBF_NUM_FRAMES, mismatches);
		if (mismatches == 0 && expected_xlates.size() == 0) begin
			$display("tlb_fifo_page_translate_unit regression: pass");
		end else begin
			$display("tlb_fifo_page_translate_unit regression: fail");
		end
		$finish;
	end

	// watchdog
	initial begin
		#5000000;
		$display("timeout with %0d translations outstanding", expected_xlates.size());
		$display("tlb_fifo_page_translate_unit regression: fail");
		$finish;
	end

endmodule
